>>> rtl/cfr_pkg.sv
// Shared types, codes and the CRC-8 byte update for the command frame receiver.
// Used by cfr_frame_tracker and command_frame_receiver_core; no dependencies.
package cfr_pkg;

  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] COUNT_MAX  = 8'hFF;

  // Frame byte offsets
  localparam logic [7:0] POS_START = 8'd0;
  localparam logic [7:0] POS_TYPE  = 8'd2;
  localparam logic [7:0] POS_BODY0 = 8'd3;
  localparam logic [7:0] POS_BODY1 = 8'd4;
  localparam logic [7:0] POS_BODY2 = 8'd5;
  localparam logic [7:0] POS_BODY3 = 8'd6;

  // Message type codes
  localparam logic [7:0] MSG_TEAM_ID   = 8'd0;
  localparam logic [7:0] MSG_TELEM_ON  = 8'd1;
  localparam logic [7:0] MSG_TELEM_OFF = 8'd2;
  localparam logic [7:0] MSG_RELEASE   = 8'd3;
  localparam logic [7:0] MSG_CALIBRATE = 8'd4;
  localparam logic [7:0] MSG_FILTER    = 8'd5;
  localparam logic [7:0] MSG_MISSION   = 8'd6;
  localparam logic [7:0] MSG_CONTAINER = 8'd253;
  localparam logic [7:0] MSG_STATION1  = 8'd254;
  localparam logic [7:0] MSG_STATION2  = 8'd255;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_CRC_ERR   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_CALIBRATE = 2'd1,
    ACT_FILTER    = 2'd2
  } action_t;

  // Frame summary: captured fields with the current byte folded in; CRC and prior byte exclude it
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  type_byte;
    logic [31:0] body_word;
    logic [7:0]  prior_byte;
    logic [7:0]  crc;
  } frame_info_t;

  // CRC-8, MSB first, one byte per call
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/cfr_frame_tracker.sv
// Per-frame state: byte position, running CRC, start/type/body capture.
// Depends on cfr_pkg.
module cfr_frame_tracker import cfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output frame_info_t info
);

  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  prior_r, prior_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] body_r, body_nxt;
  logic [7:0]  first_cap, type_cap;
  logic [31:0] body_cap;

  // Fold the current byte into the captured fields
  always_comb begin
    first_cap = first_r;
    type_cap  = type_r;
    body_cap  = body_r;
    if (byte_count_r == POS_START) begin
      first_cap = data_byte;
    end
    if (byte_count_r == POS_TYPE) begin
      type_cap = data_byte;
    end
    if (byte_count_r == POS_BODY0) begin
      body_cap[7:0] = data_byte;
    end
    if (byte_count_r == POS_BODY1) begin
      body_cap[15:8] = data_byte;
    end
    if (byte_count_r == POS_BODY2) begin
      body_cap[23:16] = data_byte;
    end
    if (byte_count_r == POS_BODY3) begin
      body_cap[31:24] = data_byte;
    end
  end

  assign info = '{first_byte: first_cap, type_byte: type_cap, body_word: body_cap,
                  prior_byte: prior_r, crc: crc_r};

  // Advance on any byte but the last, clear after the last byte
  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    prior_nxt      = prior_r;
    first_nxt      = first_r;
    type_nxt       = type_r;
    body_nxt       = body_r;
    if (step_en) begin
      if (last_byte) begin
        byte_count_nxt = '0;
        crc_nxt        = '0;
        prior_nxt      = '0;
        first_nxt      = '0;
        type_nxt       = '0;
        body_nxt       = '0;
      end else begin
        crc_nxt   = crc8_update(crc_r, data_byte);
        prior_nxt = data_byte;
        first_nxt = first_cap;
        type_nxt  = type_cap;
        body_nxt  = body_cap;
        if (byte_count_r != COUNT_MAX) begin
          byte_count_nxt = byte_count_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= '0;
      prior_r      <= '0;
      first_r      <= '0;
      type_r       <= '0;
      body_r       <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      prior_r      <= prior_nxt;
      first_r      <= first_nxt;
      type_r       <= type_nxt;
      body_r       <= body_nxt;
    end
  end

endmodule

>>> rtl/command_frame_receiver_core.sv
// Top level of the command frame receiver: input register, dispatch, result register.
// Depends on cfr_pkg and cfr_frame_tracker.
//
// Takes one frame byte per request and returns one result request on each byte
// marked last: the frame status (start byte 0x7E, then CRC-8 poly 0xD5 over all
// but the last byte), the type byte, an action code and every held field after
// the frame. A byte is accepted every cycle unless a last byte is waiting in the
// input register for the result register; a byte passes through one input
// register and one result register, the latter loading as the last byte leaves
// the input register. A full result register that is not being taken holds back
// only a last byte; other bytes keep flowing into the frame state.
module command_frame_receiver_core import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_message_type,
  output logic [1:0]         out_action,
  output logic [31:0]        out_team_id,
  output logic               out_telemetry_enabled,
  output logic [31:0]        out_filter_settings,
  output logic [31:0]        out_mission_clock,
  output logic [31:0]        out_container_pressure,
  output logic [7:0]         out_limit_switch,
  output logic signed [15:0] out_station1_temp,
  output logic signed [15:0] out_station2_temp
);

  logic        s_valid_r;
  logic [7:0]  s_byte_r;
  logic        s_last_r;
  logic        s_advance, s_fire, frame_end;
  frame_info_t info;

  logic [31:0] team_r, team_nxt;
  logic        telem_r, telem_nxt;
  logic [31:0] filter_r, filter_nxt;
  logic [31:0] mission_r, mission_nxt;
  logic [31:0] press_r, press_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic [15:0] st1_r, st1_nxt;
  logic [15:0] st2_r, st2_nxt;
  status_t     status;
  action_t     action;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [7:0]  out_type_r;
  action_t     out_action_r;

  // Stage moves unless it holds a last byte and the result slot is blocked
  assign s_advance = !s_last_r || !out_valid_r || out_ready;
  assign s_fire    = s_valid_r && s_advance;
  assign frame_end = s_fire && s_last_r;
  assign in_ready  = !s_valid_r || s_advance;

  // Hold the input request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_byte_r <= in_data_byte;
      s_last_r <= in_last_byte;
    end
  end

  cfr_frame_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s_fire),
    .data_byte (s_byte_r),
    .last_byte (s_last_r),
    .info      (info)
  );

  // Check the frame and dispatch on its type
  always_comb begin
    team_nxt    = team_r;
    telem_nxt   = telem_r;
    filter_nxt  = filter_r;
    mission_nxt = mission_r;
    press_nxt   = press_r;
    limit_nxt   = limit_r;
    st1_nxt     = st1_r;
    st2_nxt     = st2_r;
    action      = ACT_NONE;
    priority if (info.first_byte != START_MARK) begin
      status = ST_BAD_START;
    end else if (info.crc != s_byte_r) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_OK;
    end
    if (frame_end && status == ST_OK) begin
      unique case (info.type_byte)
        MSG_TEAM_ID:   team_nxt = info.body_word;
        MSG_TELEM_ON:  telem_nxt = 1'b1;
        MSG_TELEM_OFF: telem_nxt = 1'b0;
        MSG_RELEASE:   ;
        MSG_CALIBRATE: action = ACT_CALIBRATE;
        MSG_FILTER: begin
          filter_nxt = info.body_word;
          action     = ACT_FILTER;
        end
        MSG_MISSION:   mission_nxt = info.body_word;
        MSG_CONTAINER: begin
          press_nxt = info.body_word;
          limit_nxt = info.prior_byte;
        end
        MSG_STATION1:  st1_nxt = info.body_word[15:0];
        MSG_STATION2:  st2_nxt = info.body_word[15:0];
        default:       ;
      endcase
    end
  end

  // Update held fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      team_r    <= '0;
      telem_r   <= 1'b0;
      filter_r  <= '0;
      mission_r <= '0;
      press_r   <= '0;
      limit_r   <= '0;
      st1_r     <= '0;
      st2_r     <= '0;
    end else begin
      team_r    <= team_nxt;
      telem_r   <= telem_nxt;
      filter_r  <= filter_nxt;
      mission_r <= mission_nxt;
      press_r   <= press_nxt;
      limit_r   <= limit_nxt;
      st1_r     <= st1_nxt;
      st2_r     <= st2_nxt;
    end
  end

  // Load the result register at frame end, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      out_status_r <= status;
      out_type_r   <= info.type_byte;
      out_action_r <= action;
    end
  end

  // Held fields only change at frame end, so the live registers are the result
  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_message_type       = out_type_r;
  assign out_action             = out_action_r;
  assign out_team_id            = team_r;
  assign out_telemetry_enabled  = telem_r;
  assign out_filter_settings    = filter_r;
  assign out_mission_clock      = mission_r;
  assign out_container_pressure = press_r;
  assign out_limit_switch       = limit_r;
  assign out_station1_temp      = $signed(st1_r);
  assign out_station2_temp      = $signed(st2_r);

endmodule

>>> tb/cfr_result_checker.sv
// Result checker for command_frame_receiver_core: tracks accepted frame bytes, predicts
// each frame's result and compares it with the result channel field by field.
// Depends on cfr_pkg for the status and action codes, message types and frame offsets.
module cfr_result_checker import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [7:0]         out_message_type,
  input  logic [1:0]         out_action,
  input  logic [31:0]        out_team_id,
  input  logic               out_telemetry_enabled,
  input  logic [31:0]        out_filter_settings,
  input  logic [31:0]        out_mission_clock,
  input  logic [31:0]        out_container_pressure,
  input  logic [7:0]         out_limit_switch,
  input  logic signed [15:0] out_station1_temp,
  input  logic signed [15:0] out_station2_temp,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [7:0]  message_type;
    action_t     action;
    logic [31:0] team_id;
    logic        telemetry;
    logic [31:0] filter;
    logic [31:0] mission;
    logic [31:0] pressure;
    logic [7:0]  limit_sw;
    logic [15:0] station1;
    logic [15:0] station2;
  } frame_report_t;

  // Per-frame capture
  logic [7:0]  rx_count;
  logic [7:0]  rx_crc;
  logic [7:0]  rx_prior;
  logic [7:0]  rx_first;
  logic [7:0]  rx_type;
  logic [31:0] rx_body;

  // Fields held across frames
  logic [31:0] keep_team_id;
  logic        keep_telemetry;
  logic [31:0] keep_filter;
  logic [31:0] keep_mission;
  logic [31:0] keep_pressure;
  logic [7:0]  keep_limit;
  logic [15:0] keep_station1;
  logic [15:0] keep_station2;

  frame_report_t frame_reports[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t: %s got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic clear_frame();
    rx_count = '0;
    rx_crc   = '0;
    rx_prior = '0;
    rx_first = '0;
    rx_type  = '0;
    rx_body  = '0;
  endtask

  // Fold one accepted byte into the frame; on the last byte, judge and dispatch
  task automatic absorb_frame_byte(input logic [7:0] b, input logic is_last);
    logic [7:0] pos;
    frame_report_t rep;
    pos = rx_count;
    if (pos == POS_START) begin
      rx_first = b;
    end else if (pos == POS_TYPE) begin
      rx_type = b;
    end else if (pos >= POS_BODY0 && pos <= POS_BODY3) begin
      rx_body[(pos - POS_BODY0) * 8 +: 8] = b;
    end

    if (!is_last) begin
      rx_crc = crc8_fold(rx_crc, b);
      rx_prior = b;
      if (rx_count != COUNT_MAX) rx_count++;
    end else begin
      // Bad start outranks a CRC mismatch
      if (rx_first != START_MARK) begin
        rep.status = ST_BAD_START;
      end else if (rx_crc != b) begin
        rep.status = ST_CRC_ERR;
      end else begin
        rep.status = ST_OK;
      end
      rep.action = ACT_NONE;
      if (rep.status == ST_OK) begin
        case (rx_type)
          MSG_TEAM_ID:   keep_team_id = rx_body;
          MSG_TELEM_ON:  keep_telemetry = 1'b1;
          MSG_TELEM_OFF: keep_telemetry = 1'b0;
          MSG_CALIBRATE: rep.action = ACT_CALIBRATE;
          MSG_FILTER: begin
            keep_filter = rx_body;
            rep.action = ACT_FILTER;
          end
          MSG_MISSION:   keep_mission = rx_body;
          MSG_CONTAINER: begin
            keep_pressure = rx_body;
            keep_limit = rx_prior;
          end
          MSG_STATION1:  keep_station1 = rx_body[15:0];
          MSG_STATION2:  keep_station2 = rx_body[15:0];
          default: ;
        endcase
      end
      rep.message_type = rx_type;
      rep.team_id      = keep_team_id;
      rep.telemetry    = keep_telemetry;
      rep.filter       = keep_filter;
      rep.mission      = keep_mission;
      rep.pressure     = keep_pressure;
      rep.limit_sw     = keep_limit;
      rep.station1     = keep_station1;
      rep.station2     = keep_station2;
      frame_reports.push_back(rep);
      clear_frame();
    end
  endtask

  // Compare one taken result with the oldest prediction
  task automatic check_frame_result();
    frame_report_t want;
    if (frame_reports.size() == 0) begin
      report_mismatch("result with no frame pending, status", 32'(out_status), '0);
    end else begin
      want = frame_reports.pop_front();
      if (out_status !== want.status)
        report_mismatch("status", 32'(out_status), 32'(want.status));
      if (out_message_type !== want.message_type)
        report_mismatch("message_type", 32'(out_message_type), 32'(want.message_type));
      if (out_action !== want.action)
        report_mismatch("action", 32'(out_action), 32'(want.action));
      if (out_team_id !== want.team_id)
        report_mismatch("team_id", out_team_id, want.team_id);
      if (out_telemetry_enabled !== want.telemetry)
        report_mismatch("telemetry_enabled", 32'(out_telemetry_enabled),
                        32'(want.telemetry));
      if (out_filter_settings !== want.filter)
        report_mismatch("filter_settings", out_filter_settings, want.filter);
      if (out_mission_clock !== want.mission)
        report_mismatch("mission_clock", out_mission_clock, want.mission);
      if (out_container_pressure !== want.pressure)
        report_mismatch("container_pressure", out_container_pressure, want.pressure);
      if (out_limit_switch !== want.limit_sw)
        report_mismatch("limit_switch", 32'(out_limit_switch), 32'(want.limit_sw));
      if (out_station1_temp !== want.station1)
        report_mismatch("station1_temp", 32'($unsigned(out_station1_temp)),
                        32'(want.station1));
      if (out_station2_temp !== want.station2)
        report_mismatch("station2_temp", 32'($unsigned(out_station2_temp)),
                        32'(want.station2));
    end
  endtask

  // Sample both channels at the edge; inputs before outputs since a result is registered after its last byte
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      keep_team_id   = '0;
      keep_telemetry = 1'b0;
      keep_filter    = '0;
      keep_mission   = '0;
      keep_pressure  = '0;
      keep_limit     = '0;
      keep_station1  = '0;
      keep_station2  = '0;
      frame_reports.delete();
    end else begin
      if (in_valid && in_ready) absorb_frame_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) check_frame_result();
    end
    outstanding <= frame_reports.size();
  end

endmodule

>>> tb/command_frame_receiver_core_tb.sv
// Top of the command_frame_receiver_core testbench: clock, reset, frame stimulus,
// random idling on both channels, watchdog and final verdict.
// Depends on cfr_pkg, command_frame_receiver_core and cfr_result_checker.
module command_frame_receiver_core_tb import cfr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1550;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [7:0] byte_q_t[$];

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [7:0]         out_message_type;
  logic [1:0]         out_action;
  logic [31:0]        out_team_id;
  logic               out_telemetry_enabled;
  logic [31:0]        out_filter_settings;
  logic [31:0]        out_mission_clock;
  logic [31:0]        out_container_pressure;
  logic [7:0]         out_limit_switch;
  logic signed [15:0] out_station1_temp;
  logic signed [15:0] out_station2_temp;

  int mismatches;
  int outstanding;
  int sent_bytes;
  int idle_cycles;

  command_frame_receiver_core DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_message_type       (out_message_type),
    .out_action             (out_action),
    .out_team_id            (out_team_id),
    .out_telemetry_enabled  (out_telemetry_enabled),
    .out_filter_settings    (out_filter_settings),
    .out_mission_clock      (out_mission_clock),
    .out_container_pressure (out_container_pressure),
    .out_limit_switch       (out_limit_switch),
    .out_station1_temp      (out_station1_temp),
    .out_station2_temp      (out_station2_temp)
  );

  cfr_result_checker result_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_message_type       (out_message_type),
    .out_action             (out_action),
    .out_team_id            (out_team_id),
    .out_telemetry_enabled  (out_telemetry_enabled),
    .out_filter_settings    (out_filter_settings),
    .out_mission_clock      (out_mission_clock),
    .out_container_pressure (out_container_pressure),
    .out_limit_switch       (out_limit_switch),
    .out_station1_temp      (out_station1_temp),
    .out_station2_temp      (out_station2_temp),
    .mismatches             (mismatches),
    .outstanding            (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Known message types most of the time, any random byte otherwise
  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 10))
      0: return MSG_TEAM_ID;
      1: return MSG_TELEM_ON;
      2: return MSG_TELEM_OFF;
      3: return MSG_RELEASE;
      4: return MSG_CALIBRATE;
      5: return MSG_FILTER;
      6: return MSG_MISSION;
      7: return MSG_CONTAINER;
      8: return MSG_STATION1;
      9: return MSG_STATION2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Hold one request until it is taken, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic is_last, input bit no_gaps);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    gap = no_gaps ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the frame bytes, then its CRC with the given bits flipped as the last byte
  task automatic send_frame(input byte_q_t body, input logic [7:0] crc_flip,
                            input bit no_gaps);
    logic [7:0] crc;
    crc = '0;
    foreach (body[i]) begin
      crc = crc8_update(crc, body[i]);
      send_byte(body[i], 1'b0, no_gaps);
    end
    send_byte(crc ^ crc_flip, 1'b1, no_gaps);
  endtask

  // Mostly well-formed frames with random content; some bad start bytes or CRCs
  task automatic random_frame(input int len);
    byte_q_t f;
    logic [7:0] flip;
    int fill;
    int r;
    fill = $urandom_range(0, 7);
    for (int i = 0; i < len; i++) begin
      if (fill == 0) f.push_back(8'h00);
      else if (fill == 1) f.push_back(8'hFF);
      else f.push_back(8'($urandom_range(0, 255)));
    end
    if (len > 0) f[0] = START_MARK;
    if (len > 2) f[2] = pick_type();
    flip = '0;
    r = $urandom_range(0, 99);
    if (r < 9) begin
      if (len > 0) f[0] = START_MARK ^ 8'($urandom_range(1, 255));
      if (r < 4) flip = 8'($urandom_range(1, 255));
    end else if (r < 19) begin
      flip = 8'($urandom_range(1, 255));
    end
    send_frame(f, flip, $urandom_range(0, 4) == 0);
  endtask

  // Result side: ready bursts, random stalls, sometimes a long stall-free stretch
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if ($urandom_range(0, 7) == 0) repeat (150) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("command_frame_receiver_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t f;
    int r;
    int len;
    int frame_no;
    int random_start;
    sent_bytes = 0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lone zero byte: bad start
    f = {};
    send_frame(f, 8'h00, 1'b1);
    // Lone start byte: CRC over nothing is zero, so the CRC check fails
    send_frame(f, START_MARK, 1'b1);
    // Two bytes, accepted; type reads as zero so team id loads zero
    f = {START_MARK};
    send_frame(f, 8'h00, 1'b0);
    // CRC byte lands in the low body byte of a team id frame
    f = {START_MARK, 8'h00, MSG_TEAM_ID};
    send_frame(f, 8'h00, 1'b0);
    // Filter settings at all ones
    f = {START_MARK, 8'hFF, MSG_FILTER, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(f, 8'h00, 1'b0);
    // Container frame with zero pressure and all-ones limit switch
    f = {START_MARK, 8'hA5, MSG_CONTAINER, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_frame(f, 8'h00, 1'b1);

    // Random frames, some of them (frame 40 always) long enough to saturate the byte count
    frame_no = 0;
    random_start = sent_bytes;
    while (sent_bytes - random_start < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (frame_no == 40 || r == 0) len = $urandom_range(256, 280);
      else if (r < 20) len = $urandom_range(0, 6);
      else if (r < 85) len = $urandom_range(7, 9);
      else len = $urandom_range(10, 24);
      random_frame(len);
      frame_no++;
    end
    in_valid <= 1'b0;

    // Let the checker count the last frame, drain it, then watch for strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outstanding != 0) $display("%0d frame results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("command_frame_receiver_core: match");
    end else begin
      $display("command_frame_receiver_core: mismatch");
    end
    $finish;
  end

endmodule
